[rtl/bdth_pkg.sv]
package bdth_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int LEVEL_BITS  = 3;
    localparam int CODE_W      = 3;
    localparam int TIME_W      = 32;
    localparam int MS_W        = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 2;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code EV_NONE = 3'd0;
    localparam t_code EV_HOLD = 3'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEBOUNCE    = 2'd0,
        CFG_LONG_PRESS  = 2'd1,
        CFG_ACTIVE_HIGH = 2'd2,
        CFG_HOLD_MASK   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic              last_level;
        logic              stable_level;
        logic              hold_reported;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] press_time;
    } t_btn_state;

    // Tap code of a button: its index plus one, kept to the code width
    function automatic t_code tap_code(input int idx);
        return CODE_W'(idx + 1);
    endfunction

endpackage

[rtl/bdth_lane.sv]
module bdth_lane (
    input  logic               i_func,
    input  logic               i_level,
    input  logic [31:0]        i_now_ms,
    input  bdth_pkg::t_btn_state i_state,
    input  bdth_pkg::t_cfg     i_cfg,
    input  logic               i_hold_en,
    input  bdth_pkg::t_code    i_tap_code,
    output bdth_pkg::t_btn_state o_state,
    output bdth_pkg::t_code    o_code
);
    import bdth_pkg::*;

    logic              changed;
    logic              deb_ok;
    logic              settle;
    logic              new_press;
    logic              tap;
    logic              press_ok;
    logic [TIME_W-1:0] change_diff;
    logic [TIME_W-1:0] press_diff;

    assign change_diff = i_now_ms - i_state.change_time;
    assign press_diff  = i_now_ms - i_state.press_time;

    always_comb begin
        changed = (i_level != i_state.last_level);
        // a fresh change has zero elapsed time
        deb_ok  = changed ? (i_cfg.debounce_ms == '0)
                          : (change_diff >= TIME_W'(i_cfg.debounce_ms));
        settle    = deb_ok && (i_level != i_state.stable_level);
        new_press = settle && i_level;
        tap       = settle && !i_level && !i_state.hold_reported;
        press_ok  = new_press ? (i_cfg.long_press_ms == '0)
                              : (press_diff >= TIME_W'(i_cfg.long_press_ms));

        o_state = i_state;
        o_code  = EV_NONE;
        if (changed) begin
            o_state.last_level  = i_level;
            o_state.change_time = i_now_ms;
        end
        if (settle) begin
            o_state.stable_level = i_level;
            if (i_level) begin
                o_state.press_time    = i_now_ms;
                o_state.hold_reported = 1'b0;
            end
        end
        if (tap) begin
            o_code = i_tap_code;
        end else if (o_state.stable_level && !o_state.hold_reported && i_hold_en
                     && press_ok) begin
            o_state.hold_reported = 1'b1;
            o_code                = EV_HOLD;
        end

        if (i_func) begin
            o_state.last_level    = i_level;
            o_state.stable_level  = i_level;
            o_state.hold_reported = 1'b0;
            o_state.change_time   = i_now_ms;
            o_state.press_time    = i_level ? i_now_ms : '0;
            o_code                = EV_NONE;
        end
    end

endmodule

[rtl/bdth_merge.sv]
module bdth_merge (
    input  logic [bdth_pkg::NUM_BUTTONS-1:0][bdth_pkg::CODE_W-1:0] i_codes,
    output logic [bdth_pkg::NUM_BUTTONS-1:0]                       o_commit,
    output bdth_pkg::t_code                                        o_code
);
    import bdth_pkg::*;

    logic found;

    // first lane with an event wins; lanes after it keep their state
    always_comb begin
        found    = 1'b0;
        o_code   = EV_NONE;
        o_commit = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            o_commit[i] = !found;
            if (!found && i_codes[i] != EV_NONE) begin
                found  = 1'b1;
                o_code = i_codes[i];
            end
        end
    end

endmodule

[rtl/button_debounce_tap_hold.sv]
// Debouncer for a row of buttons with tap and long-press events. Each item
// carries the raw levels and a millisecond timestamp; func 1 loads the state
// from the levels, func 0 runs one update and yields one event code (0 none,
// button index + 1 for a tap, 4 for a hold). The block takes one item per
// clock while the output is drained: one lane per button evaluates its
// debounce and hold timers in the same cycle, a priority merge keeps the
// first event and the result sits in an output register in the cycle after
// acceptance. A new item is taken whenever that register is empty or being
// emptied. Write configuration only while no item is in flight.
module button_debounce_tap_hold (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bdth_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bdth_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_func,
    input  logic [bdth_pkg::LEVEL_BITS-1:0]  i_raw_levels,
    input  logic [31:0]                      i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bdth_pkg::CODE_W-1:0]      o_event_code
);
    import bdth_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_active_high;
    logic [LEVEL_BITS-1:0]  r_hold_mask;
    t_btn_state             r_state [NUM_BUTTONS];
    t_btn_state             n_state [NUM_BUTTONS];
    logic                   r_out_valid;
    t_code                  r_event;

    logic [NUM_BUTTONS-1:0]             lane_level;
    logic [NUM_BUTTONS-1:0]             lane_hold_en;
    logic [NUM_BUTTONS-1:0][CODE_W-1:0] lane_code;
    logic [NUM_BUTTONS-1:0]             commit;
    logic [NUM_BUTTONS-1:0]             hold_vec;
    t_code                              merged_code;
    logic                               in_fire;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign in_fire      = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= MS_W'(50);
            r_cfg.long_press_ms <= MS_W'(800);
            r_active_high       <= 1'b0;
            r_hold_mask         <= LEVEL_BITS'(4);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_DEBOUNCE:    r_cfg.debounce_ms   <= i_cfg_wdata[MS_W-1:0];
                CFG_LONG_PRESS:  r_cfg.long_press_ms <= i_cfg_wdata[MS_W-1:0];
                CFG_ACTIVE_HIGH: r_active_high       <= i_cfg_wdata[0];
                CFG_HOLD_MASK:   r_hold_mask         <= i_cfg_wdata[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++) begin : g_lane
            if (g < LEVEL_BITS) begin : g_pin
                assign lane_level[g]   = i_raw_levels[g] ^ !r_active_high;
                assign lane_hold_en[g] = r_hold_mask[g];
            end else begin : g_nopin
                assign lane_level[g]   = !r_active_high;
                assign lane_hold_en[g] = 1'b0;
            end

            bdth_lane u_lane (
                .i_func     (i_func),
                .i_level    (lane_level[g]),
                .i_now_ms   (i_now_ms),
                .i_state    (r_state[g]),
                .i_cfg      (r_cfg),
                .i_hold_en  (lane_hold_en[g]),
                .i_tap_code (tap_code(g)),
                .o_state    (n_state[g]),
                .o_code     (lane_code[g])
            );

            assign hold_vec[g] = r_state[g].hold_reported;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_state[g] <= '0;
                end else if (in_fire && commit[g]) begin
                    r_state[g] <= n_state[g];
                end
            end
        end
    endgenerate

    bdth_merge u_merge (
        .i_codes  (lane_code),
        .o_commit (commit),
        .o_code   (merged_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_event <= merged_code;
        end
    end

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted item produced no result");

    a_init_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_func) |=> (r_event == EV_NONE && hold_vec == '0))
        else $error("initialize item produced an event or kept a hold flag");

    // a re-press can clear and set the same flag on one item, so only
    // require that some flag is set after a hold event
    a_hold_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_func) |=> (r_event != EV_HOLD || hold_vec != '0))
        else $error("hold event without a hold flag set");

    a_single_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_func) |=> $countones(hold_vec & ~$past(hold_vec)) <= 1)
        else $error("more than one hold flag set by one item");

endmodule

[dv/button_debounce_tap_hold_test.sv]
module button_debounce_tap_hold_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdth_pkg::*;

    localparam logic FN_STEP = 1'b0;
    localparam logic FN_INIT = 1'b1;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata  = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic                  i_func       = 1'b0;
    logic [LEVEL_BITS-1:0] i_raw_levels = '0;
    logic [31:0]           i_now_ms     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [CODE_W-1:0]     o_event_code;

    button_debounce_tap_hold dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_raw_levels (i_raw_levels),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_code (o_event_code)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted copy of the debouncer: configuration and per-button state
    logic [MS_W-1:0]       m_debounce;
    logic [MS_W-1:0]       m_long_press;
    logic                  m_active_high;
    logic [LEVEL_BITS-1:0] m_hold_mask;
    t_btn_state            btn [NUM_BUTTONS];

    t_code pending_codes [$];

    int  n_items     = 0;
    int  n_taps      = 0;
    int  n_holds     = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  n_settings  = 0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_stall_en = 1'b1;
    int  rx_stall_left = 0;

    function automatic void reset_predictor();
        m_debounce    = 16'd50;
        m_long_press  = 16'd800;
        m_active_high = 1'b0;
        m_hold_mask   = 3'd4;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn[b] = '0;
        end
    endfunction

    function automatic logic level_of(logic [LEVEL_BITS-1:0] raw, int b);
        return m_active_high ? raw[b] : ~raw[b];
    endfunction

    // Pin levels for a set of pressed buttons (the mapping is its own inverse)
    function automatic logic [LEVEL_BITS-1:0] levels_for(logic [LEVEL_BITS-1:0] pressed);
        return m_active_high ? pressed : ~pressed;
    endfunction

    function automatic t_code debounce_button(int b, logic lvl, logic [31:0] stamp);
        logic [31:0] held_for;
        logic [31:0] pressed_for;
        if (lvl != btn[b].last_level) begin
            btn[b].last_level  = lvl;
            btn[b].change_time = stamp;
        end
        held_for = stamp - btn[b].change_time;
        if (held_for >= 32'(m_debounce) && lvl != btn[b].stable_level) begin
            btn[b].stable_level = lvl;
            if (lvl) begin
                btn[b].press_time    = stamp;
                btn[b].hold_reported = 1'b0;
            end else if (!btn[b].hold_reported) begin
                return t_code'(b + 1);
            end
        end
        pressed_for = stamp - btn[b].press_time;
        if (btn[b].stable_level && !btn[b].hold_reported && m_hold_mask[b] &&
            pressed_for >= 32'(m_long_press)) begin
            btn[b].hold_reported = 1'b1;
            return EV_HOLD;
        end
        return EV_NONE;
    endfunction

    function automatic t_code predict_event(logic func, logic [LEVEL_BITS-1:0] raw,
                                            logic [31:0] stamp);
        t_code code;
        logic  lvl;
        code = EV_NONE;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            lvl = level_of(raw, b);
            if (func == FN_INIT) begin
                btn[b].last_level    = lvl;
                btn[b].stable_level  = lvl;
                btn[b].change_time   = stamp;
                btn[b].press_time    = lvl ? stamp : '0;
                btn[b].hold_reported = 1'b0;
            end else if (code == EV_NONE) begin
                // first event wins, later buttons keep their state
                code = debounce_button(b, lvl, stamp);
            end
        end
        return code;
    endfunction

    task automatic send_item(logic func, logic [LEVEL_BITS-1:0] raw, logic [31:0] stamp);
        t_code code;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_raw_levels <= raw;
        i_now_ms     <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        code = predict_event(func, raw, stamp);
        pending_codes.push_back(code);
        n_items++;
        if (code == EV_HOLD)
            n_holds++;
        else if (code != EV_NONE)
            n_taps++;
    endtask

    // Hold the sender until every outstanding result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [MS_W-1:0] deb, logic [MS_W-1:0] lp, logic ah,
                              logic [LEVEL_BITS-1:0] mask);
        wait_drained();
        repeat (2) @(posedge i_clk);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_ACTIVE_HIGH, CFG_DATA_W'(ah));
        write_reg(CFG_HOLD_MASK, CFG_DATA_W'(mask));
        i_cfg_we      <= 1'b0;
        m_debounce    = deb;
        m_long_press  = lp;
        m_active_high = ah;
        m_hold_mask   = mask;
        n_settings++;
    endtask

    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_out_ready   <= 1'b0;
        end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(0, 6);
            i_out_ready   <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_code want_code;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: event_code %0d with no item pending", $time, o_event_code);
                n_errors++;
            end else begin
                want_code = pending_codes.pop_front();
                n_results++;
                if (o_event_code !== want_code) begin
                    $display("%0t: event_code mismatch, expected %0d, actual %0d",
                             $time, want_code, o_event_code);
                    n_errors++;
                end
            end
        end
    end

    // Reset defaults, active low: select hold, no tap after hold, previous tap
    task automatic test_default_tap_hold();
        send_item(FN_STEP, 3'b111, 32'd0);
        send_item(FN_STEP, 3'b011, 32'd10);
        send_item(FN_STEP, 3'b011, 32'd60);
        send_item(FN_STEP, 3'b011, 32'd860);
        send_item(FN_STEP, 3'b111, 32'd870);
        send_item(FN_STEP, 3'b111, 32'd920);
        send_item(FN_STEP, 3'b110, 32'd1000);
        send_item(FN_STEP, 3'b110, 32'd1049);
        send_item(FN_STEP, 3'b110, 32'd1050);
        send_item(FN_STEP, 3'b111, 32'd1100);
        send_item(FN_STEP, 3'b111, 32'd1150);
    endtask

    // Zero times give the hold on the press item; maximum times across the wrap
    task automatic test_zero_and_max_times();
        set_config(16'd0, 16'd0, 1'b1, 3'd7);
        send_item(FN_INIT, 3'b000, 32'hFFFF_FFFF);
        send_item(FN_STEP, 3'b111, 32'd0);
        send_item(FN_STEP, 3'b111, 32'd0);
        send_item(FN_STEP, 3'b111, 32'd0);
        send_item(FN_STEP, 3'b000, 32'd1);
        set_config(16'hFFFF, 16'hFFFF, 1'b0, 3'd0);
        send_item(FN_INIT, 3'b111, 32'hFFFF_FFF0);
        send_item(FN_STEP, 3'b101, 32'hFFFF_FFF0);
        send_item(FN_STEP, 3'b101, 32'h0000_FFEE);
        send_item(FN_STEP, 3'b101, 32'h0000_FFEF);
        send_item(FN_STEP, 3'b111, 32'h0001_0000);
        send_item(FN_STEP, 3'b111, 32'h0001_FFFF);
    endtask

    // Simultaneous releases come out one per item in button order
    task automatic test_tap_priority();
        set_config(16'd5, 16'd100, 1'b1, 3'd0);
        send_item(FN_INIT, 3'b000, 32'd100);
        send_item(FN_STEP, 3'b111, 32'd100);
        send_item(FN_STEP, 3'b111, 32'd105);
        send_item(FN_STEP, 3'b000, 32'd110);
        send_item(FN_STEP, 3'b000, 32'd115);
        send_item(FN_STEP, 3'b000, 32'd115);
        send_item(FN_STEP, 3'b000, 32'd115);
    endtask

    task automatic run_traffic(int n, int pause_at);
        logic [LEVEL_BITS-1:0] pressed;
        logic [LEVEL_BITS-1:0] raw;
        logic [31:0]           stamp;
        logic                  fn;
        int                    b;
        stamp   = $urandom();
        pressed = '0;
        if ($urandom_range(0, 3) != 0)
            send_item(FN_INIT, levels_for(pressed), stamp);
        for (int k = 0; k < n; k++) begin
            fn  = FN_STEP;
            b   = $urandom_range(0, NUM_BUTTONS - 1);
            raw = levels_for(pressed);
            case ($urandom_range(0, 19))
                0: begin
                    fn      = FN_INIT;
                    raw     = LEVEL_BITS'($urandom_range(0, 7));
                    pressed = levels_for(raw);
                    stamp   = stamp + $urandom_range(0, 100);
                end
                1: begin
                    // noise: arbitrary levels at an arbitrary time
                    raw   = LEVEL_BITS'($urandom_range(0, 7));
                    stamp = $urandom();
                end
                2, 3, 4: begin
                    pressed[b] = ~pressed[b];
                    raw        = levels_for(pressed);
                    stamp      = stamp + $urandom_range(0, 2);
                end
                5, 6, 7, 8: begin
                    // contact bounce well inside the debounce window
                    raw   = levels_for(pressed) ^ LEVEL_BITS'($urandom_range(0, 7));
                    stamp = stamp + $urandom_range(0, m_debounce / 2);
                end
                9, 10, 11, 12, 13: begin
                    stamp = btn[b].change_time + 32'(m_debounce) - $urandom_range(0, 1);
                end
                14, 15, 16: begin
                    stamp = btn[b].press_time + 32'(m_long_press) - $urandom_range(0, 1);
                end
                default: begin
                    stamp = stamp + $urandom_range(0, 2 * m_long_press + 10);
                end
            endcase
            send_item(fn, raw, stamp);
            if (k == pause_at)
                wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_config(16'd50, 16'd800, 1'b0, 3'd4);
                1: set_config(16'd0, 16'd0, 1'b1, 3'd7);
                2: set_config(16'hFFFF, 16'hFFFF, 1'b0, 3'd7);
                3: set_config(16'd3, 16'd20, 1'b1, 3'd3);
                7: set_config(16'd20, 16'd150, 1'b0, 3'd7);
                default: set_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)),
                                    1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            endcase
            // last phase runs at full rate on both sides
            tx_idle_en  = (phase != 5) && (phase != 7);
            rx_stall_en = (phase != 4) && (phase != 7);
            run_traffic(128, (phase == 2) ? 64 : -1);
        end
    endtask

    initial begin
        int guard;
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_tap_hold();
        test_zero_and_max_times();
        test_tap_priority();
        test_random_traffic();
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_codes.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_codes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_codes.size());
            n_errors++;
        end
        $display("sent %0d items over %0d register settings, %0d results checked",
                 n_items, n_settings + 1, n_results);
        $display("events seen: %0d taps, %0d holds", n_taps, n_holds);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
